[rtl/cbct_pkg.sv]
// Shared widths, command codes and pipeline stage types for the collision test.
package cbct_pkg;

  localparam int COORD_BITS = 16;
  localparam int SIZE_BITS  = COORD_BITS - 1;
  localparam int BND_BITS   = COORD_BITS + 2;
  localparam int DIFF_BITS  = BND_BITS + 1;
  localparam int SQ_BITS    = 2 * COORD_BITS;

  typedef enum logic [1:0] {
    CMD_CC = 2'd0,
    CMD_BB = 2'd1,
    CMD_CB = 2'd2,
    CMD_BC = 2'd3
  } cmd_t;

  typedef struct packed {
    logic is_bb;
    logic is_cc;
    logic bb_hit;
  } kind_t;

  // Stage load enables, one per payload stage.
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
  } pipe_en_t;

  typedef struct packed {
    kind_t                        kind;
    logic signed [BND_BITS-1:0]   cx;
    logic signed [BND_BITS-1:0]   cy;
    logic signed [BND_BITS-1:0]   lox;
    logic signed [BND_BITS-1:0]   loy;
    logic signed [BND_BITS-1:0]   hix;
    logic signed [BND_BITS-1:0]   hiy;
    logic [COORD_BITS-1:0]        rad;
  } s1_t;

  typedef struct packed {
    kind_t                        kind;
    logic signed [BND_BITS-1:0]   cx;
    logic signed [BND_BITS-1:0]   cy;
    logic signed [BND_BITS-1:0]   tx;
    logic signed [BND_BITS-1:0]   ty;
    logic [COORD_BITS-1:0]        rad;
  } s2_t;

  typedef struct packed {
    kind_t                        kind;
    logic [COORD_BITS-1:0]        mx;
    logic [COORD_BITS-1:0]        my;
    logic [COORD_BITS-1:0]        rad;
  } s3_t;

  typedef struct packed {
    kind_t                        kind;
    logic [SQ_BITS-1:0]           sx;
    logic [SQ_BITS-1:0]           sy;
    logic [SQ_BITS-1:0]           rsq;
  } s4_t;

endpackage

[rtl/cbct_prep.sv]
// Stage 1: pick circle and box operands per pair kind, run the box-box test.
module cbct_prep (
  input  logic                                  clk,
  input  logic                                  ld,
  input  logic [1:0]                            cmd,
  input  logic signed [cbct_pkg::COORD_BITS-1:0] ax,
  input  logic signed [cbct_pkg::COORD_BITS-1:0] ay,
  input  logic [cbct_pkg::SIZE_BITS-1:0]        ar,
  input  logic [cbct_pkg::SIZE_BITS-1:0]        aw,
  input  logic [cbct_pkg::SIZE_BITS-1:0]        ah,
  input  logic signed [cbct_pkg::COORD_BITS-1:0] bx,
  input  logic signed [cbct_pkg::COORD_BITS-1:0] by,
  input  logic [cbct_pkg::SIZE_BITS-1:0]        br,
  input  logic [cbct_pkg::SIZE_BITS-1:0]        bw,
  input  logic [cbct_pkg::SIZE_BITS-1:0]        bh,
  output cbct_pkg::s1_t                         s1
);
  import cbct_pkg::*;

  logic signed [BND_BITS-1:0] ax_e, ay_e, bx_e, by_e;
  logic signed [BND_BITS-1:0] aw_e, ah_e, bw_e, bh_e;
  logic signed [BND_BITS-1:0] aw2_e, ah2_e, bw2_e, bh2_e;
  cmd_t                       kind_cmd;
  s1_t                        s1_nxt;
  s1_t                        s1_r;

  assign ax_e  = {{2{ax[COORD_BITS-1]}}, ax};
  assign ay_e  = {{2{ay[COORD_BITS-1]}}, ay};
  assign bx_e  = {{2{bx[COORD_BITS-1]}}, bx};
  assign by_e  = {{2{by[COORD_BITS-1]}}, by};
  assign aw_e  = {3'b000, aw};
  assign ah_e  = {3'b000, ah};
  assign bw_e  = {3'b000, bw};
  assign bh_e  = {3'b000, bh};
  assign aw2_e = {2'b00, aw, 1'b0};
  assign ah2_e = {2'b00, ah, 1'b0};
  assign bw2_e = {2'b00, bw, 1'b0};
  assign bh2_e = {2'b00, bh, 1'b0};
  assign kind_cmd = cmd_t'(cmd);

  always_comb begin
    s1_nxt             = '0;
    s1_nxt.kind.is_bb  = (kind_cmd == CMD_BB);
    s1_nxt.kind.is_cc  = (kind_cmd == CMD_CC);
    s1_nxt.kind.bb_hit = (ax_e < bx_e + bw_e) && (ax_e + aw_e > bx_e) &&
                         (ay_e < by_e + bh_e) && (ay_e + ah_e > by_e);
    case (kind_cmd)
      CMD_CC: begin
        // Collapse the box to the second centre so the clamp returns it.
        s1_nxt.cx  = ax_e;
        s1_nxt.cy  = ay_e;
        s1_nxt.lox = bx_e;
        s1_nxt.loy = by_e;
        s1_nxt.hix = bx_e;
        s1_nxt.hiy = by_e;
        s1_nxt.rad = {1'b0, ar} + {1'b0, br};
      end
      CMD_BC: begin
        s1_nxt.cx  = bx_e;
        s1_nxt.cy  = by_e;
        s1_nxt.lox = ax_e;
        s1_nxt.loy = ay_e;
        s1_nxt.hix = ax_e + aw2_e;
        s1_nxt.hiy = ay_e + ah2_e;
        s1_nxt.rad = {1'b0, br};
      end
      default: begin
        s1_nxt.cx  = ax_e;
        s1_nxt.cy  = ay_e;
        s1_nxt.lox = bx_e;
        s1_nxt.loy = by_e;
        s1_nxt.hix = bx_e + bw2_e;
        s1_nxt.hiy = by_e + bh2_e;
        s1_nxt.rad = {1'b0, ar};
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (ld) begin
      s1_r <= s1_nxt;
    end
  end

  assign s1 = s1_r;

endmodule

[rtl/cbct_clamp.sv]
// Stages 2 and 3: clamp the centre into the box, then take the offset magnitudes.
module cbct_clamp (
  input  logic               clk,
  input  logic               ld2,
  input  logic               ld3,
  input  cbct_pkg::s1_t      s1,
  output cbct_pkg::s3_t      s3
);
  import cbct_pkg::*;

  s2_t                         s2_nxt, s2_r;
  s3_t                         s3_nxt, s3_r;
  logic signed [DIFF_BITS-1:0] dx, dy;
  logic signed [DIFF_BITS-1:0] ndx, ndy;

  always_comb begin
    s2_nxt      = '0;
    s2_nxt.kind = s1.kind;
    s2_nxt.cx   = s1.cx;
    s2_nxt.cy   = s1.cy;
    s2_nxt.rad  = s1.rad;
    if (s1.cx < s1.lox) begin
      s2_nxt.tx = s1.lox;
    end else if (s1.cx > s1.hix) begin
      s2_nxt.tx = s1.hix;
    end else begin
      s2_nxt.tx = s1.cx;
    end
    if (s1.cy < s1.loy) begin
      s2_nxt.ty = s1.loy;
    end else if (s1.cy > s1.hiy) begin
      s2_nxt.ty = s1.hiy;
    end else begin
      s2_nxt.ty = s1.cy;
    end
  end

  assign dx  = {s2_r.cx[BND_BITS-1], s2_r.cx} - {s2_r.tx[BND_BITS-1], s2_r.tx};
  assign dy  = {s2_r.cy[BND_BITS-1], s2_r.cy} - {s2_r.ty[BND_BITS-1], s2_r.ty};
  assign ndx = -dx;
  assign ndy = -dy;

  // The offset magnitude to the clamped point always fits in COORD_BITS unsigned bits.
  always_comb begin
    s3_nxt      = '0;
    s3_nxt.kind = s2_r.kind;
    s3_nxt.rad  = s2_r.rad;
    s3_nxt.mx   = dx[DIFF_BITS-1] ? ndx[COORD_BITS-1:0] : dx[COORD_BITS-1:0];
    s3_nxt.my   = dy[DIFF_BITS-1] ? ndy[COORD_BITS-1:0] : dy[COORD_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (ld2) begin
      s2_r <= s2_nxt;
    end
    if (ld3) begin
      s3_r <= s3_nxt;
    end
  end

  assign s3 = s3_r;

endmodule

[rtl/cbct_square.sv]
// Stage 4: square both offset magnitudes and the radius.
module cbct_square (
  input  logic               clk,
  input  logic               ld,
  input  cbct_pkg::s3_t      s3,
  output cbct_pkg::s4_t      s4
);
  import cbct_pkg::*;

  s4_t s4_nxt, s4_r;

  always_comb begin
    s4_nxt      = '0;
    s4_nxt.kind = s3.kind;
    s4_nxt.sx   = SQ_BITS'(s3.mx) * SQ_BITS'(s3.mx);
    s4_nxt.sy   = SQ_BITS'(s3.my) * SQ_BITS'(s3.my);
    s4_nxt.rsq  = SQ_BITS'(s3.rad) * SQ_BITS'(s3.rad);
  end

  always_ff @(posedge clk) begin
    if (ld) begin
      s4_r <= s4_nxt;
    end
  end

  assign s4 = s4_r;

endmodule

[rtl/circle_box_collision_test.sv]
// Top level: five-stage pipelined circle/box collision test with output register.
//
// Each input item is one pair of shapes and a pair kind (in_cmd): circle-circle,
// box-box, circle-box or box-circle. Every item gives exactly one result item,
// out_hit, in the order the items were taken.
// An item is taken at a clock edge with in_valid high and in_stall low; a
// result leaves at an edge with out_valid high and out_stall low.
// Each item passes through operand select, clamp, offset magnitude, square and
// compare, each registered, before its result shows on out_valid.
// Throughput: one item per cycle while in_stall is low; every stage holds its own
// valid bit, so empty stages fill even while the output register waits.
// When the receiver stalls, the output holds its result and the stages behind
// it keep advancing until full; in_stall rises only once all four inner
// stages and the output register hold items. Nothing is dropped or repeated.
// Reset (rst_n low, synchronous) empties every stage; no clearing time is
// needed afterwards.
module circle_box_collision_test (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [1:0]                            in_cmd,
  input  logic signed [cbct_pkg::COORD_BITS-1:0] in_first_x,
  input  logic signed [cbct_pkg::COORD_BITS-1:0] in_first_y,
  input  logic [cbct_pkg::SIZE_BITS-1:0]        in_first_radius,
  input  logic [cbct_pkg::SIZE_BITS-1:0]        in_first_width,
  input  logic [cbct_pkg::SIZE_BITS-1:0]        in_first_height,
  input  logic signed [cbct_pkg::COORD_BITS-1:0] in_second_x,
  input  logic signed [cbct_pkg::COORD_BITS-1:0] in_second_y,
  input  logic [cbct_pkg::SIZE_BITS-1:0]        in_second_radius,
  input  logic [cbct_pkg::SIZE_BITS-1:0]        in_second_width,
  input  logic [cbct_pkg::SIZE_BITS-1:0]        in_second_height,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic                                  out_hit
);
  import cbct_pkg::*;

  pipe_en_t           en;
  logic               en_out;
  logic               v1_r, v2_r, v3_r, v4_r;
  logic               out_valid_r;
  logic               out_hit_r, out_hit_nxt;
  s1_t                s1;
  s3_t                s3;
  s4_t                s4;
  logic [SQ_BITS:0]   dist_sq;

  // A stage advances when it is empty or the one after it advances.
  assign en_out = !out_valid_r || !out_stall;
  assign en.s4  = !v4_r || en_out;
  assign en.s3  = !v3_r || en.s4;
  assign en.s2  = !v2_r || en.s3;
  assign en.s1  = !v1_r || en.s2;
  assign in_stall = !en.s1;

  cbct_prep u_prep (
    .clk (clk),
    .ld  (en.s1),
    .cmd (in_cmd),
    .ax  (in_first_x),
    .ay  (in_first_y),
    .ar  (in_first_radius),
    .aw  (in_first_width),
    .ah  (in_first_height),
    .bx  (in_second_x),
    .by  (in_second_y),
    .br  (in_second_radius),
    .bw  (in_second_width),
    .bh  (in_second_height),
    .s1  (s1)
  );

  cbct_clamp u_clamp (
    .clk (clk),
    .ld2 (en.s2),
    .ld3 (en.s3),
    .s1  (s1),
    .s3  (s3)
  );

  cbct_square u_square (
    .clk (clk),
    .ld  (en.s4),
    .s3  (s3),
    .s4  (s4)
  );

  assign dist_sq = {1'b0, s4.sx} + {1'b0, s4.sy};

  // Circle pairs hit only on strict overlap of the radius sum; circle-box counts touch as a hit.
  always_comb begin
    if (s4.kind.is_bb) begin
      out_hit_nxt = s4.kind.bb_hit;
    end else if (s4.kind.is_cc) begin
      out_hit_nxt = dist_sq < {1'b0, s4.rsq};
    end else begin
      out_hit_nxt = dist_sq <= {1'b0, s4.rsq};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (en.s1) begin
        v1_r <= in_valid;
      end
      if (en.s2) begin
        v2_r <= v1_r;
      end
      if (en.s3) begin
        v3_r <= v2_r;
      end
      if (en.s4) begin
        v4_r <= v3_r;
      end
      if (en_out) begin
        out_valid_r <= v4_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en_out && v4_r) begin
      out_hit_r <= out_hit_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_hit   = out_hit_r;

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (v1_r && v2_r && v3_r && v4_r && out_valid_r && out_stall))
    else $error("input stalled while the pipeline has room");

  a_result_moves_out: assert property (@(posedge clk) disable iff (!rst_n)
    (v4_r && en_out) |=> out_valid_r)
    else $error("item in last stage lost on its way to the output");

  a_reset_empties: assert property (@(posedge clk)
    !rst_n |=> (!v1_r && !v2_r && !v3_r && !v4_r && !out_valid_r))
    else $error("pipeline not empty after reset");

  a_drain_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_stall && !v4_r) |=> !out_valid_r)
    else $error("result repeated after it was taken");

endmodule
